// ===== hw/rtl/dns_wildcard_a_responder_assert.svh =====
// Assertion macros for the responder modules, included by the emitter
`ifndef DNS_WILDCARD_A_RESPONDER_ASSERT_SVH
`define DNS_WILDCARD_A_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DWA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dwa assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dwa assertion failed");

`endif

// ===== hw/rtl/dwa_pkg.sv =====
// Types, constants and byte tables for the DNS wildcard A responder
package dwa_pkg;

    localparam int unsigned POS_W     = 10;
    localparam int unsigned LEFT_W    = 5;
    localparam logic [POS_W-1:0] HDR_LEN    = 10'd12;
    localparam logic [POS_W-1:0] LABEL_RST  = 10'd12;
    localparam logic [POS_W-1:0] POS_SAT    = 10'd1023;
    localparam logic [LEFT_W-1:0] MAX_ITEMS = 5'd17;
    localparam logic [31:0] ADDR_RESET      = 32'hC0A8_0401;
    localparam logic [31:0] TTL_RESET       = 32'd60;

    // Configuration register indexes
    localparam logic CFG_ADDRESS = 1'b0;
    localparam logic CFG_TTL     = 1'b1;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ANSWER,
        TAIL_DROP
    } t_tail;

    // Work handed from the parser to the emitter for one input byte
    typedef struct packed {
        logic        hdr;
        logic        echo;
        logic [7:0]  echo_byte;
        logic [15:0] id;
        t_tail       tail;
    } t_job;

    // Saturate an offset to the 10-bit position range
    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
        sat_pos = v[POS_W] ? POS_SAT : v[POS_W-1:0];
    endfunction

    // Rewritten header bytes 0 to 5
    function automatic logic [7:0] hdr_byte(input logic [2:0] k, input logic [15:0] id);
        unique case (k)
            3'd0:    hdr_byte = id[15:8];
            3'd1:    hdr_byte = id[7:0];
            3'd2:    hdr_byte = 8'h81;
            3'd3:    hdr_byte = 8'h80;
            3'd4:    hdr_byte = 8'h00;
            3'd5:    hdr_byte = 8'h01;
            default: hdr_byte = 8'h00;
        endcase
    endfunction

    // A record appended after the question
    function automatic logic [7:0] ans_byte(input logic [3:0] t, input logic [31:0] ttl,
                                            input logic [31:0] addr);
        unique case (t)
            4'd0:    ans_byte = 8'hC0;
            4'd1:    ans_byte = 8'h0C;
            4'd2:    ans_byte = 8'h00;
            4'd3:    ans_byte = 8'h01;
            4'd4:    ans_byte = 8'h00;
            4'd5:    ans_byte = 8'h01;
            4'd6:    ans_byte = ttl[31:24];
            4'd7:    ans_byte = ttl[23:16];
            4'd8:    ans_byte = ttl[15:8];
            4'd9:    ans_byte = ttl[7:0];
            4'd10:   ans_byte = 8'h00;
            4'd11:   ans_byte = 8'h04;
            4'd12:   ans_byte = addr[31:24];
            4'd13:   ans_byte = addr[23:16];
            4'd14:   ans_byte = addr[15:8];
            default: ans_byte = addr[7:0];
        endcase
    endfunction

endpackage

// ===== hw/rtl/dwa_parser.sv =====
// Input register and datagram parser: tracks header and question, issues one job per byte
module dwa_parser
    import dwa_pkg::*;
#(
    parameter int unsigned MAX_DATAGRAM = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_DATAGRAM);
    localparam logic [POS_W:0]   MAX_EXT = (POS_W+1)'(MAX_DATAGRAM);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_next, n_next;
    logic             r_ended, n_ended;
    logic [POS_W-1:0] r_qend, n_qend;
    logic [15:0]      r_id, n_id;
    logic             r_acc, n_acc;

    logic             take;
    logic             ok;
    t_job             job;

    assign take        = r_in_valid & i_job_ready;
    assign o_ready     = ~r_in_valid | take;
    assign o_job_valid = r_in_valid;
    assign o_job       = job;

    // Decode the held byte against the datagram state
    always_comb begin
        n_pos         = r_pos;
        n_next        = r_next;
        n_ended       = r_ended;
        n_qend        = r_qend;
        n_id          = r_id;
        n_acc         = r_acc;
        job.hdr       = 1'b0;
        job.echo      = 1'b0;
        job.echo_byte = r_in_byte;
        job.id        = r_id;
        job.tail      = TAIL_NONE;
        ok            = 1'b0;

        if (r_pos < MAX_POS) begin
            if (r_pos == 10'd0) begin
                n_id  = {r_in_byte, 8'h00};
                n_acc = 1'b1;
            end else if (r_pos == 10'd1) begin
                n_id[7:0] = r_in_byte;
            end else if (r_pos == 10'd2) begin
                if (r_in_byte[7]) n_acc = 1'b0;
            end else if (r_pos == 10'd4) begin
                if (r_in_byte != 8'd0) n_acc = 1'b0;
            end else if (r_pos == 10'd5) begin
                if (r_in_byte != 8'd1) n_acc = 1'b0;
                job.hdr = n_acc;
            end else if (r_pos >= 10'd6 && r_pos < HDR_LEN) begin
                job.echo      = r_acc;
                job.echo_byte = (r_pos == 10'd7) ? 8'd1 : 8'd0;
            end else if (r_pos >= HDR_LEN) begin
                if (!r_ended) begin
                    if (r_pos == r_next) begin
                        if (r_in_byte == 8'd0) begin
                            n_ended = 1'b1;
                            n_qend  = sat_pos({1'b0, r_pos} + 11'd5);
                        end else begin
                            n_next = sat_pos({1'b0, r_pos} + {3'b000, r_in_byte} + 11'd1);
                        end
                    end
                    job.echo = r_acc;
                end else if (r_pos < r_qend) begin
                    job.echo = r_acc;
                end
            end
            n_pos = r_pos + 10'd1;
        end

        // Close the datagram: answer or drop, then clear
        if (r_in_last) begin
            ok = n_acc & n_ended & (n_qend <= n_pos) & (({1'b0, n_qend} + 11'd16) <= MAX_EXT);
            job.tail = ok ? TAIL_ANSWER : TAIL_DROP;
            n_pos   = '0;
            n_next  = LABEL_RST;
            n_ended = 1'b0;
            n_qend  = '0;
            n_id    = '0;
            n_acc   = 1'b0;
        end
    end

    // Hold the input byte until the emitter takes its job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // Advance datagram state on each job transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_next  <= LABEL_RST;
            r_ended <= 1'b0;
            r_qend  <= '0;
            r_id    <= '0;
            r_acc   <= 1'b0;
        end else if (take) begin
            r_pos   <= n_pos;
            r_next  <= n_next;
            r_ended <= n_ended;
            r_qend  <= n_qend;
            r_id    <= n_id;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== hw/rtl/dwa_emitter.sv =====
// Job register and output register: expands each job into response bytes
module dwa_emitter
    import dwa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    input  logic [31:0] i_ttl,
    input  logic [31:0] i_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last,
    output logic        o_drop
);

`include "dns_wildcard_a_responder_assert.svh"

    t_job              r_job;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] r_idx;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_drop;

    logic              slot_free;
    logic              fire;
    logic              load;
    logic [2:0]        head_len;
    logic              in_head;
    logic [LEFT_W-1:0] tail_idx;
    logic [7:0]        item_byte;
    logic              item_last;
    logic              item_drop;
    logic [LEFT_W-1:0] job_count;

    assign slot_free   = ~r_out_valid | i_ready;
    assign fire        = (r_left != '0) & slot_free;
    assign o_job_ready = (r_left == '0) | ((r_left == 5'd1) & fire);
    assign load        = i_job_valid & o_job_ready;

    // Pick the item at the current index: header or echo first, then the tail
    always_comb begin
        head_len  = r_job.hdr ? 3'd6 : (r_job.echo ? 3'd1 : 3'd0);
        in_head   = r_idx < {2'b00, head_len};
        tail_idx  = r_idx - {2'b00, head_len};
        item_last = 1'b0;
        item_drop = 1'b0;
        if (in_head) begin
            item_byte = r_job.hdr ? hdr_byte(r_idx[2:0], r_job.id) : r_job.echo_byte;
        end else if (r_job.tail == TAIL_DROP) begin
            item_byte = 8'h00;
            item_last = 1'b1;
            item_drop = 1'b1;
        end else begin
            item_byte = ans_byte(tail_idx[3:0], i_ttl, i_addr);
            item_last = (r_left == 5'd1);
        end
    end

    // Count items in an incoming job
    always_comb begin
        job_count = '0;
        if (i_job.hdr) begin
            job_count = 5'd6;
        end else if (i_job.echo) begin
            job_count = 5'd1;
        end
        unique case (i_job.tail)
            TAIL_ANSWER: job_count = job_count + 5'd16;
            TAIL_DROP:   job_count = job_count + 5'd1;
            default:     job_count = job_count;
        endcase
    end

    // Load jobs and step through their items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (load) begin
            r_left <= job_count;
            r_idx  <= '0;
        end else if (fire) begin
            r_left <= r_left - 5'd1;
            r_idx  <= r_idx + 5'd1;
        end
        if (load) begin
            r_job <= i_job;
        end
    end

    // Hold the output item until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= fire;
        end
        if (fire) begin
            r_out_byte <= item_byte;
            r_out_last <= item_last;
            r_out_drop <= item_drop;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_drop  = r_out_drop;

    `DWA_ASSERT_NOW(a_left_bound, i_clk, i_rst_n, 1'b1, r_left <= MAX_ITEMS)
    `DWA_ASSERT_NOW(a_drop_is_last, i_clk, i_rst_n, r_out_valid && r_out_drop, r_out_last)
    `DWA_ASSERT_NOW(a_load_when_done, i_clk, i_rst_n, load, r_left <= 5'd1)
    `DWA_ASSERT_NEXT(a_job_drains, i_clk, i_rst_n, fire && r_left == 5'd1 && !load,
                     r_left == 5'd0)

endmodule

// ===== hw/rtl/dns_wildcard_a_responder.sv =====
// Top level of the DNS wildcard A responder: configuration registers and datapath
//
//  channel  | direction | tdata        | tlast    | tuser
//  s_axis   | in        | rx_byte[7:0] | rx_last  | -
//  m_axis   | out       | tx_byte[7:0] | tx_last  | tx_drop
//  i_cfg    | in        | i_cfg_data: register value, i_cfg_index: 0 address, 1 ttl
//
// One datagram byte per cycle, unless m_axis_tready is low or a header or record is
// being emitted, passes input register, parser, job register and output register.
// The byte at offset 5 expands into the rewritten header and the final byte into
// the echo plus A record, emitted one byte at a time by the single output register.
// Reset is synchronous and needs no clearing pass; control and configuration registers return to defaults.
// Low m_axis_tready holds the output register; the job and input registers then
// fill and s_axis_tready falls.
module dns_wildcard_a_responder
    import dwa_pkg::*;
#(
    parameter int unsigned MAX_DATAGRAM = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] tx_drop
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_addr;
    logic [31:0] r_ttl;
    logic        job_valid;
    logic        job_ready;
    t_job        job;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= ADDR_RESET;
            r_ttl  <= TTL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ADDRESS: r_addr <= i_cfg_data;
                CFG_TTL:     r_ttl  <= i_cfg_data;
                default:     r_ttl  <= r_ttl;
            endcase
        end
    end

    dwa_parser #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    dwa_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .i_ttl       (r_ttl),
        .i_addr      (r_addr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_drop      (m_axis_tuser)
    );

endmodule

// ===== test/dns_wildcard_a_responder_checker.sv =====
// Scoreboard for the DNS wildcard A responder: predicts the response stream and checks it
module dns_wildcard_a_responder_checker #(
    parameter int unsigned MAX_DATAGRAM = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,   // [0] tx_drop
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dwa_pkg::CFG_ADDRESS;
    import dwa_pkg::CFG_TTL;

    localparam logic [31:0] ADDRESS_DEFAULT = 32'hC0A8_0401;
    localparam logic [31:0] TTL_DEFAULT     = 32'd60;
    localparam int unsigned QNAME_START     = 12;
    localparam int unsigned OFFSET_MAX      = 1023;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } t_tx_item;

    // Register copies and per-datagram parser state
    logic [31:0] answer_address;
    logic [31:0] answer_ttl;
    logic [9:0]  byte_pos;
    logic [9:0]  label_at;
    logic [9:0]  qclass_end;
    logic        name_done;
    logic        hdr_ok;
    logic [15:0] query_id;

    t_tx_item tx_expected[$];
    int       fail_count = 0;

    function automatic void restart_datagram();
        byte_pos   = '0;
        label_at   = 10'(QNAME_START);
        name_done  = 1'b0;
        qclass_end = '0;
        query_id   = '0;
        hdr_ok     = 1'b0;
    endfunction

    function automatic void push_tx(input logic [7:0] data, input logic last, input logic drop);
        t_tx_item item;
        item.data = data;
        item.last = last;
        item.drop = drop;
        tx_expected.push_back(item);
    endfunction

    // Work out the response bytes caused by one received byte
    function automatic void predict_response(input logic [7:0] rx, input logic rx_last);
        logic [9:0]   p;
        int unsigned  span;
        logic [47:0]  header;
        logic [127:0] record;
        logic         ok;
        if (byte_pos < MAX_DATAGRAM) begin
            p = byte_pos;
            if (p == 0) begin
                query_id = {rx, 8'h00};
                hdr_ok   = 1'b1;
            end else if (p == 1) begin
                query_id[7:0] = rx;
            end else if (p == 2) begin
                if (rx[7]) hdr_ok = 1'b0;
            end else if (p == 4) begin
                if (rx != 8'h00) hdr_ok = 1'b0;
            end else if (p == 5) begin
                if (rx != 8'h01) hdr_ok = 1'b0;
                if (hdr_ok) begin
                    header = {query_id, 16'h8180, 16'h0001};
                    for (int k = 0; k < 6; k++) push_tx(header[47 - 8 * k -: 8], 1'b0, 1'b0);
                end
            end else if (p >= 6 && p < QNAME_START) begin
                if (hdr_ok) push_tx((p == 7) ? 8'h01 : 8'h00, 1'b0, 1'b0);
            end else if (p >= QNAME_START) begin
                if (!name_done) begin
                    // Walk the name by its length bytes; any value counts as a length
                    if (p == label_at) begin
                        if (rx == 8'h00) begin
                            name_done = 1'b1;
                            span = int'(p) + 5;
                            qclass_end = (span > OFFSET_MAX) ? 10'(OFFSET_MAX) : 10'(span);
                        end else begin
                            span = int'(p) + int'(rx) + 1;
                            label_at = (span > OFFSET_MAX) ? 10'(OFFSET_MAX) : 10'(span);
                        end
                    end
                    if (hdr_ok) push_tx(rx, 1'b0, 1'b0);
                end else if (p < qclass_end) begin
                    if (hdr_ok) push_tx(rx, 1'b0, 1'b0);
                end
            end
            byte_pos = p + 10'd1;
        end

        // Close the datagram: append the A record or a single drop item
        if (rx_last) begin
            ok = hdr_ok && name_done && (qclass_end <= byte_pos) &&
                 (int'(qclass_end) + 16 <= MAX_DATAGRAM);
            if (ok) begin
                record = {16'hC00C, 16'h0001, 16'h0001, answer_ttl, 16'h0004, answer_address};
                for (int k = 0; k < 16; k++) begin
                    push_tx(record[127 - 8 * k -: 8], k == 15, 1'b0);
                end
            end else begin
                push_tx(8'h00, 1'b1, 1'b1);
            end
            restart_datagram();
        end
    endfunction

    function automatic void note_failure(input string what, input t_tx_item want,
                                         input t_tx_item got);
        if (fail_count < 10) begin
            $display("%0t: %s: expected byte %02h last %0b drop %0b, got byte %02h last %0b drop %0b",
                     $realtime, what, want.data, want.last, want.drop,
                     got.data, got.last, got.drop);
        end
        fail_count++;
    endfunction

    // Track register writes and byte transfers, then compare each output transfer
    always @(posedge i_clk) begin : scoreboard
        t_tx_item got;
        t_tx_item want;
        if (!i_rst_n) begin
            answer_address = ADDRESS_DEFAULT;
            answer_ttl     = TTL_DEFAULT;
            restart_datagram();
            tx_expected.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ADDRESS) begin
                    answer_address = i_cfg_data;
                end else if (i_cfg_index == CFG_TTL) begin
                    answer_ttl = i_cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_response(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.data = m_axis_tdata;
                got.last = m_axis_tlast;
                got.drop = m_axis_tuser;
                if (tx_expected.size() == 0) begin
                    want = '0;
                    note_failure("response transfer with nothing pending", want, got);
                end else begin
                    want = tx_expected.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.drop !== want.drop) begin
                        note_failure("response mismatch", want, got);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= tx_expected.size();
    end

endmodule

// ===== test/dns_wildcard_a_responder_tb.sv =====
// Testbench top for the DNS wildcard A responder: clock, reset, stimulus, stalls and verdict
module dns_wildcard_a_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwa_pkg::CFG_ADDRESS;
    import dwa_pkg::CFG_TTL;

    localparam int unsigned MAX_DATAGRAM    = 512;
    localparam int unsigned ITEMS_PER_PHASE = 22;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;

    typedef enum logic [1:0] {
        FRAME_QUERY,
        FRAME_TRUNCATED,
        FRAME_REJECTED,
        FRAME_NOISE
    } t_frame_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = 32'h0;

    int         fail_count;
    int         pending;
    logic       steady = 1'b0;
    logic [7:0] frame_bytes[$];

    dns_wildcard_a_responder #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    dns_wildcard_a_responder_checker #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the response side now and then, except during the steady stretch
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 12);
    end

    // Hold the write until the register channel takes it
    task automatic write_reg(input logic index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_answer(input logic [31:0] address, input logic [31:0] ttl);
        write_reg(CFG_ADDRESS, address);
        write_reg(CFG_TTL, ttl);
        i_cfg_valid <= 1'b0;
    endtask

    // Well-formed query whose root label sits at root_pos, then QTYPE, QCLASS and padding
    task automatic build_query(input int unsigned root_pos, input int unsigned trailing);
        int unsigned left;
        int unsigned len;
        frame_bytes.delete();
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom_range(127)));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        repeat (6) frame_bytes.push_back(8'($urandom));
        left = root_pos - 12;
        while (left > 0) begin
            len = $urandom_range((left - 1 > 63) ? 63 : left - 1, 1);
            // never leave a single byte, it could not hold a label
            if (left - len - 1 == 1) len++;
            frame_bytes.push_back(8'(len));
            repeat (len) frame_bytes.push_back(8'($urandom));
            left -= len + 1;
        end
        frame_bytes.push_back(8'h00);
        repeat (4 + trailing) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic build_random(input t_frame_kind kind);
        int unsigned name_len;
        int unsigned cut;
        name_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(30, 2);
        build_query(12 + name_len, ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0);
        case (kind)
            FRAME_TRUNCATED: begin
                if ($urandom_range(2) == 0) begin
                    // pointer-like length byte jumps past the end, so the root is never met
                    frame_bytes[12] = 8'($urandom_range(255, 64));
                end else begin
                    cut = $urandom_range(frame_bytes.size() - 1, 1);
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end
            end
            FRAME_REJECTED: begin
                case ($urandom_range(2))
                    0:       frame_bytes[2] = frame_bytes[2] | 8'h80;
                    1:       frame_bytes[4] = 8'($urandom_range(255, 1));
                    default: frame_bytes[5] = $urandom_range(1) ? 8'h00
                                                                : 8'($urandom_range(255, 2));
                endcase
            end
            FRAME_NOISE: begin
                frame_bytes.delete();
                repeat ($urandom_range(24, 1)) frame_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // Stream the frame out, one transfer per byte, with random gaps outside the steady stretch
    task automatic send_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++) begin
            while (!steady && $urandom_range(99) < 12) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_bytes[k];
            s_axis_tlast  <= (k == frame_bytes.size() - 1);
            do @(posedge i_clk); while (!s_axis_tready);
        end
    endtask

    // Drop valid, wait for every expected byte, then let the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned pick;
        t_frame_kind kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte datagram, minimal query with all-ones fields, response bit set
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01};
        send_frame();
        drain();

        // Random phases, each under its own answer settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       load_answer(32'h0000_0000, 32'h0000_0000);
                1:       load_answer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: load_answer($urandom, $urandom);
            endcase
            steady <= (phase == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                kind = (pick < 60) ? FRAME_QUERY :
                       (pick < 75) ? FRAME_TRUNCATED :
                       (pick < 90) ? FRAME_REJECTED : FRAME_NOISE;
                build_random(kind);
                send_frame();
                sent += frame_bytes.size();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("dns_wildcard_a_responder verification clean");
        end else begin
            $display("dns_wildcard_a_responder verification failed");
        end
        $finish;
    end

    // End the run when no channel has moved a transfer for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("dns_wildcard_a_responder verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dwa_pkg.sv
hw/rtl/dwa_parser.sv
hw/rtl/dwa_emitter.sv
hw/rtl/dns_wildcard_a_responder.sv
test/dns_wildcard_a_responder_checker.sv
test/dns_wildcard_a_responder_tb.sv
